// File: rtl/gda_pkg.sv
// shared types, constants and calendar functions for the date adder
package gda_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int CNT_IN_W = 16;
    localparam int ST_W    = 2;

    localparam int DAY_COUNT_BITS_DEF = 16;

    localparam logic [YEAR_W-1:0] MAX_YEAR = YEAR_W'(9999);
    localparam logic [4:0] FEB_LEAP_LEN = 5'd29;
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID  = 2'd1;
    localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [DAY_W-1:0] MONTH_LEN [1:12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    // controller to datapath
    typedef struct packed {
        logic load;
        logic reduce;
        logic check;
        logic step;
        logic finish;
    } t_gda_cmd;

    // datapath to controller
    typedef struct packed {
        logic last;
    } t_gda_sts;

    // divisible by 4 and not by 100, or divisible by 400
    function automatic logic is_leap(input logic [1:0] y_lo,
                                     input logic [6:0] y_mod100,
                                     input logic [8:0] y_mod400);
        return ((y_lo == 2'd0) && (y_mod100 != 7'd0)) || (y_mod400 == 9'd0);
    endfunction

    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
        logic [DAY_W-1:0] len;
        len = 5'd31;
        if (m >= MONTH_JAN && m <= MONTH_DEC) begin
            len = MONTH_LEN[m];
        end
        if (m == MONTH_FEB && leap) begin
            len = FEB_LEAP_LEN;
        end
        return len;
    endfunction

endpackage

// File: rtl/gda_if.sv
// valid/ready channel interfaces for start dates and result dates
interface gda_in_if;
    logic                            valid;
    logic                            ready;
    logic [gda_pkg::DAY_W-1:0]       start_day;
    logic [gda_pkg::MONTH_W-1:0]     start_month;
    logic [gda_pkg::YEAR_W-1:0]      start_year;
    logic [gda_pkg::CNT_IN_W-1:0]    add_count;

    modport source (output valid, start_day, start_month, start_year, add_count,
                    input ready);
    modport sink (input valid, start_day, start_month, start_year, add_count,
                  output ready);
endinterface

interface gda_out_if;
    logic                            valid;
    logic                            ready;
    logic [gda_pkg::DAY_W-1:0]       end_day;
    logic [gda_pkg::MONTH_W-1:0]     end_month;
    logic [gda_pkg::YEAR_W-1:0]      end_year;
    logic [gda_pkg::ST_W-1:0]        status;

    modport source (output valid, end_day, end_month, end_year, status,
                    input ready);
    modport sink (input valid, end_day, end_month, end_year, status,
                  output ready);
endinterface

// File: rtl/gda_ctrl.sv
// sequencer: load, year reduction, validity check, month walk, result hand-off
module gda_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    input  gda_pkg::t_gda_sts i_sts,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output gda_pkg::t_gda_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_REDUCE,
        S_CHECK,
        S_WALK
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.reduce = (r_state == S_REDUCE);
        o_cmd.check  = (r_state == S_CHECK);
        // the last step must wait for a free output register
        o_cmd.step   = (r_state == S_WALK) && (!i_sts.last || out_free);
        o_cmd.finish = (r_state == S_WALK) && i_sts.last && out_free;
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_REDUCE;
                end
            end
            S_REDUCE: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = S_WALK;
            end
            S_WALK: begin
                if (o_cmd.finish) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/gda_dp.sv
// datapath: date registers, year residues, one month step per cycle (the last step waits for a free output register)
module gda_dp #(
    parameter int DAY_COUNT_BITS = gda_pkg::DAY_COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  gda_pkg::t_gda_cmd              i_cmd,
    input  logic [gda_pkg::DAY_W-1:0]      i_start_day,
    input  logic [gda_pkg::MONTH_W-1:0]    i_start_month,
    input  logic [gda_pkg::YEAR_W-1:0]     i_start_year,
    input  logic [gda_pkg::CNT_IN_W-1:0]   i_add_count,
    output gda_pkg::t_gda_sts              o_sts,
    output logic [gda_pkg::DAY_W-1:0]      o_end_day,
    output logic [gda_pkg::MONTH_W-1:0]    o_end_month,
    output logic [gda_pkg::YEAR_W-1:0]     o_end_year,
    output logic [gda_pkg::ST_W-1:0]       o_status
);

    localparam int CNT_W = (DAY_COUNT_BITS < gda_pkg::CNT_IN_W) ?
                           DAY_COUNT_BITS : gda_pkg::CNT_IN_W;
    localparam int DAY_W = gda_pkg::DAY_W;
    localparam int MONTH_W = gda_pkg::MONTH_W;
    localparam int YEAR_W = gda_pkg::YEAR_W;
    localparam int REDUCE_STEPS = 6;
    localparam logic [8:0] MOD400_TOP = 9'd399;
    localparam logic [6:0] MOD100_TOP = 7'd99;

    logic [DAY_W-1:0]   r_d, n_d;
    logic [MONTH_W-1:0] r_m, n_m;
    logic [YEAR_W-1:0]  r_y, n_y;
    logic [CNT_W-1:0]   r_rem, n_rem;
    logic [8:0]         r_y400, n_y400;
    logic [6:0]         r_y100, n_y100;
    logic               r_invalid, n_invalid;
    logic               r_ovf, n_ovf;

    logic [DAY_W-1:0]   r_out_d;
    logic [MONTH_W-1:0] r_out_m;
    logic [YEAR_W-1:0]  r_out_y;
    logic [gda_pkg::ST_W-1:0] r_out_st;

    logic [YEAR_W-1:0]  red_y;
    logic [8:0]         chk_y400;
    logic [6:0]         chk_y100;
    logic               leap_chk;
    logic               leap_cur;
    logic [DAY_W-1:0]   dim_chk;
    logic [DAY_W-1:0]   dim;
    logic [CNT_W:0]     sum;
    logic               fits;
    logic               year_end;
    logic [DAY_W-1:0]   consume;
    logic [gda_pkg::ST_W-1:0] st_next;

    // year mod 400 by restoring subtraction of 400 * 2^k
    always_comb begin
        red_y = r_y;
        for (int k = REDUCE_STEPS - 1; k >= 0; k--) begin
            if (red_y >= YEAR_W'(400 << k)) begin
                red_y = red_y - YEAR_W'(400 << k);
            end
        end
    end

    // year mod 100 from year mod 400
    always_comb begin
        chk_y400 = r_y400;
        if (chk_y400 >= 9'd200) begin
            chk_y400 = chk_y400 - 9'd200;
        end
        if (chk_y400 >= 9'd100) begin
            chk_y400 = chk_y400 - 9'd100;
        end
        chk_y100 = chk_y400[6:0];
    end

    assign leap_chk = gda_pkg::is_leap(r_y[1:0], chk_y100, r_y400);
    assign dim_chk  = gda_pkg::days_in(r_m, leap_chk);
    assign leap_cur = gda_pkg::is_leap(r_y[1:0], r_y100, r_y400);
    assign dim      = gda_pkg::days_in(r_m, leap_cur);
    assign sum      = (CNT_W+1)'(r_d) + (CNT_W+1)'(r_rem);
    assign fits     = sum <= (CNT_W+1)'(dim);
    assign year_end = (r_m == gda_pkg::MONTH_DEC) && (r_y == gda_pkg::MAX_YEAR);
    assign consume  = dim - r_d + DAY_W'(1);

    assign o_sts.last = r_invalid || (r_rem == '0) || fits || year_end;

    always_comb begin
        n_d       = r_d;
        n_m       = r_m;
        n_y       = r_y;
        n_rem     = r_rem;
        n_y400    = r_y400;
        n_y100    = r_y100;
        n_invalid = r_invalid;
        n_ovf     = r_ovf;
        if (i_cmd.load) begin
            n_d       = i_start_day;
            n_m       = i_start_month;
            n_y       = i_start_year;
            n_rem     = i_add_count[CNT_W-1:0];
            n_invalid = 1'b0;
            n_ovf     = 1'b0;
        end else if (i_cmd.reduce) begin
            n_y400 = red_y[8:0];
        end else if (i_cmd.check) begin
            n_y100    = chk_y100;
            n_invalid = !(r_m inside {[gda_pkg::MONTH_JAN:gda_pkg::MONTH_DEC]})
                        || (r_y > gda_pkg::MAX_YEAR) || (r_d == '0) || (r_d > dim_chk);
        end else if (i_cmd.step && !r_invalid && (r_rem != '0)) begin
            if (fits) begin
                n_d   = sum[DAY_W-1:0];
                n_rem = '0;
            end else begin
                n_rem = r_rem - CNT_W'(consume);
                n_d   = DAY_W'(1);
                if (r_m == gda_pkg::MONTH_DEC) begin
                    if (r_y == gda_pkg::MAX_YEAR) begin
                        // saturate at the last day of the last year
                        n_d   = DAY_W'(31);
                        n_m   = gda_pkg::MONTH_DEC;
                        n_ovf = 1'b1;
                    end else begin
                        n_m    = gda_pkg::MONTH_JAN;
                        n_y    = r_y + YEAR_W'(1);
                        n_y400 = (r_y400 == MOD400_TOP) ? 9'd0 : r_y400 + 9'd1;
                        n_y100 = (r_y100 == MOD100_TOP) ? 7'd0 : r_y100 + 7'd1;
                    end
                end else begin
                    n_m = r_m + MONTH_W'(1);
                end
            end
        end
    end

    always_comb begin
        st_next = gda_pkg::ST_OK;
        if (n_invalid) begin
            st_next = gda_pkg::ST_INVALID;
        end else if (n_ovf) begin
            st_next = gda_pkg::ST_OVERFLOW;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d       <= n_d;
        r_m       <= n_m;
        r_y       <= n_y;
        r_rem     <= n_rem;
        r_y400    <= n_y400;
        r_y100    <= n_y100;
        r_invalid <= n_invalid;
        r_ovf     <= n_ovf;
        if (i_cmd.finish) begin
            r_out_d  <= n_d;
            r_out_m  <= n_m;
            r_out_y  <= n_y;
            r_out_st <= st_next;
        end
    end

    assign o_end_day   = r_out_d;
    assign o_end_month = r_out_m;
    assign o_end_year  = r_out_y;
    assign o_status    = r_out_st;

endmodule

// File: rtl/gregorian_date_add_days_core.sv
// steps from input transfer to result: year reduction, validity check, month walk
// the walk advances one month per cycle through a single day-count subtractor,
// the last step waiting for a free output; the next item is taken while a result waits
// reset: synchronous active-low i_rst_n clears the sequencer and the output valid
// date and count registers are not reset
module gregorian_date_add_days_core #(
    parameter int DAY_COUNT_BITS = gda_pkg::DAY_COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gda_in_if.sink     i_in,
    gda_out_if.source  o_out
);

    gda_pkg::t_gda_cmd cmd;
    gda_pkg::t_gda_sts sts;

    gda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (cmd)
    );

    gda_dp #(
        .DAY_COUNT_BITS (DAY_COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_cmd         (cmd),
        .i_start_day   (i_in.start_day),
        .i_start_month (i_in.start_month),
        .i_start_year  (i_in.start_year),
        .i_add_count   (i_in.add_count),
        .o_sts         (sts),
        .o_end_day     (o_out.end_day),
        .o_end_month   (o_out.end_month),
        .o_end_year    (o_out.end_year),
        .o_status      (o_out.status)
    );

    // one item in flight: no new transfer right after one is taken
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an item is in flight");

    a_overflow_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == gda_pkg::ST_OVERFLOW) |->
        (o_out.end_day == 5'd31 && o_out.end_month == gda_pkg::MONTH_DEC &&
         o_out.end_year == gda_pkg::MAX_YEAR))
        else $error("overflow result not saturated");

    a_ok_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status == gda_pkg::ST_OK) |->
        (o_out.end_month >= gda_pkg::MONTH_JAN && o_out.end_month <= gda_pkg::MONTH_DEC &&
         o_out.end_day != 5'd0 && o_out.end_year <= gda_pkg::MAX_YEAR))
        else $error("ok result is not a calendar date");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.status == gda_pkg::ST_OK ||
                         o_out.status == gda_pkg::ST_INVALID ||
                         o_out.status == gda_pkg::ST_OVERFLOW))
        else $error("undefined status code");

endmodule

// File: sim/tb.sv
// self-checking testbench for the gregorian date adder core
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CNT_BITS   = gda_pkg::DAY_COUNT_BITS_DEF;
    localparam int RAND_ITEMS = 270;

    typedef struct packed {
        logic [gda_pkg::DAY_W-1:0]    day;
        logic [gda_pkg::MONTH_W-1:0]  month;
        logic [gda_pkg::YEAR_W-1:0]   year;
        logic [gda_pkg::CNT_IN_W-1:0] days;
    } t_date_start;

    typedef struct packed {
        logic [gda_pkg::DAY_W-1:0]   day;
        logic [gda_pkg::MONTH_W-1:0] month;
        logic [gda_pkg::YEAR_W-1:0]  year;
        logic [gda_pkg::ST_W-1:0]    status;
    } t_date_result;

    class t_date_scoreboard;
        t_date_result expected_dates[$];
        int           mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        static function int unsigned month_days(int unsigned m, int unsigned y);
            bit leap_year;
            leap_year = ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
            case (m)
                4, 6, 9, 11: return 30;
                2:           return leap_year ? 29 : 28;
                default:     return 31;
            endcase
        endfunction

        // walk month by month until the remaining count fits in the current month or the year passes MAX_YEAR
        static function t_date_result add_days(t_date_start s);
            int unsigned  d;
            int unsigned  m;
            int unsigned  y;
            int unsigned  rem;
            int unsigned  dim;
            t_date_result r;
            d = s.day;
            m = s.month;
            y = s.year;
            rem = (CNT_BITS >= gda_pkg::CNT_IN_W) ? s.days :
                  (s.days & ((32'd1 << CNT_BITS) - 1));
            r.status = gda_pkg::ST_OK;
            if (m < 1 || m > 12 || y > gda_pkg::MAX_YEAR || d < 1 ||
                d > month_days(m, y)) begin
                r.status = gda_pkg::ST_INVALID;
            end else begin
                while (rem > 0) begin
                    dim = month_days(m, y);
                    if (d + rem <= dim) begin
                        d = d + rem;
                        rem = 0;
                    end else begin
                        rem = rem - (dim - d + 1);
                        d = 1;
                        m = m + 1;
                        if (m > 12) begin
                            m = 1;
                            y = y + 1;
                            if (y > gda_pkg::MAX_YEAR) begin
                                d = 31;
                                m = 12;
                                y = gda_pkg::MAX_YEAR;
                                r.status = gda_pkg::ST_OVERFLOW;
                                break;
                            end
                        end
                    end
                end
            end
            r.day   = gda_pkg::DAY_W'(d);
            r.month = gda_pkg::MONTH_W'(m);
            r.year  = gda_pkg::YEAR_W'(y);
            return r;
        endfunction

        function void note_start(t_date_start s);
            expected_dates.push_back(add_days(s));
        endfunction

        function void check_result(t_date_result got);
            t_date_result want;
            if (expected_dates.size() == 0) begin
                $error("result transfer with no date expected: %0d-%0d-%0d status %0d",
                       got.day, got.month, got.year, got.status);
                mismatch_count++;
                return;
            end
            want = expected_dates.pop_front();
            if (got.day !== want.day) begin
                $error("end_day: expected %0d, got %0d", want.day, got.day);
                mismatch_count++;
            end
            if (got.month !== want.month) begin
                $error("end_month: expected %0d, got %0d", want.month, got.month);
                mismatch_count++;
            end
            if (got.year !== want.year) begin
                $error("end_year: expected %0d, got %0d", want.year, got.year);
                mismatch_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatch_count++;
            end
        endfunction

        function int pending();
            return expected_dates.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    t_date_scoreboard sb;

    gda_in_if  in_if ();
    gda_out_if out_if ();

    gregorian_date_add_days_core u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always #10 clk = ~clk;

    // one start date per call, held until the transfer
    task automatic send_date(input t_date_start s);
        int gap;
        gap = $urandom_range(0, 19);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.start_day   = s.day;
        in_if.start_month = s.month;
        in_if.start_year  = s.year;
        in_if.add_count   = s.days;
        in_if.valid       = 1'b1;
        do @(posedge clk); while (!in_if.ready);
        sb.note_start(s);
        @(negedge clk);
    endtask

    task automatic send_fixed(input int d, input int m, input int y, input int n);
        t_date_start s;
        s.day   = gda_pkg::DAY_W'(d);
        s.month = gda_pkg::MONTH_W'(m);
        s.year  = gda_pkg::YEAR_W'(y);
        s.days  = gda_pkg::CNT_IN_W'(n);
        send_date(s);
    endtask

    // mostly well-formed dates, the rest raw bit patterns
    function automatic t_date_start random_start();
        t_date_start s;
        int          pick;
        int unsigned m;
        int unsigned y;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
            m = $urandom_range(1, 12);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                y = $urandom_range(9800, 9999);
            end else if (pick == 1) begin
                y = $urandom_range(0, 400);
            end else begin
                y = $urandom_range(0, 9999);
            end
            s.month = gda_pkg::MONTH_W'(m);
            s.year  = gda_pkg::YEAR_W'(y);
            s.day   = gda_pkg::DAY_W'($urandom_range(1,
                                      t_date_scoreboard::month_days(m, y)));
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                s.days = gda_pkg::CNT_IN_W'($urandom_range(0, 31));
            end else if (pick < 6) begin
                s.days = gda_pkg::CNT_IN_W'($urandom_range(0, 2000));
            end else begin
                s.days = gda_pkg::CNT_IN_W'($urandom());
            end
        end else begin
            s.day   = gda_pkg::DAY_W'($urandom());
            s.month = gda_pkg::MONTH_W'($urandom());
            s.year  = gda_pkg::YEAR_W'($urandom());
            s.days  = gda_pkg::CNT_IN_W'($urandom());
        end
        return s;
    endfunction

    initial begin
        #60000000;
        $display("CHECK FAILED");
        $finish;
    end

    // result side: random stalls, check every transfer
    initial begin
        int           stall;
        t_date_result got;
        out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever begin
            stall = $urandom_range(0, 19);
            if (stall > 0) begin
                out_if.ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_if.ready = 1'b1;
            do @(posedge clk); while (!out_if.valid);
            got.day    = out_if.end_day;
            got.month  = out_if.end_month;
            got.year   = out_if.end_year;
            got.status = out_if.status;
            sb.check_result(got);
            @(negedge clk);
        end
    end

    initial begin
        sb = new();
        in_if.valid       = 1'b0;
        in_if.start_day   = '0;
        in_if.start_month = '0;
        in_if.start_year  = '0;
        in_if.add_count   = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: range ends, leap rules, invalid dates, year saturation
        send_fixed(1, 1, 0, 0);
        send_fixed(31, 12, 9999, 0);
        send_fixed(31, 12, 9999, 1);
        send_fixed(28, 2, 2023, 1);
        send_fixed(28, 2, 2024, 1);
        send_fixed(29, 2, 2024, 1);
        send_fixed(28, 2, 1900, 1);
        send_fixed(28, 2, 2000, 1);
        send_fixed(29, 2, 2023, 0);
        send_fixed(29, 2, 1900, 5);
        send_fixed(31, 4, 2020, 3);
        send_fixed(0, 5, 2020, 10);
        send_fixed(15, 0, 2020, 10);
        send_fixed(15, 13, 2020, 10);
        send_fixed(31, 15, 16383, 65535);
        send_fixed(10, 6, 10000, 7);
        send_fixed(1, 1, 0, 65535);
        send_fixed(1, 1, 9900, 65535);
        send_fixed(31, 12, 2023, 1);
        send_fixed(1, 1, 9999, 364);
        send_fixed(1, 1, 9999, 365);
        send_fixed(31, 1, 2021, 29);
        send_fixed(15, 7, 5000, 65535);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            send_date(random_start());
        end
        in_if.valid = 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
